@@ sv/equal_width_binning_top_assert.svh @@
// assertion macros for the equal-width binning discretizer
`ifndef EQUAL_WIDTH_BINNING_TOP_ASSERT_SVH
`define EQUAL_WIDTH_BINNING_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define EWB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define EWB_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define EWB_ASSERT(label, prop, msg)
`define EWB_ASSERT_NEVER(label, cond, msg)
`endif
`endif

@@ sv/ewb_pkg.sv @@
// shared types and constants of the equal-width binning discretizer
package ewb_pkg;

   localparam int VALUE_BITS = 32;
   localparam int ATTR_BITS  = 6;
   localparam int BIN_BITS   = 6;
   localparam int NB_BITS    = 7;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [NB_BITS-1:0] MAX_BINS       = 7'd64;
   localparam logic [NB_BITS-1:0] NUM_BINS_RESET = 7'd10;
   localparam logic signed [VALUE_BITS-1:0] ONE_Q16 = 32'sh0001_0000;

   // register index is paddr bit 2
   localparam logic REG_NUM_BINS = 1'b0;

   localparam logic CMD_OBSERVE  = 1'b0;
   localparam logic CMD_CLASSIFY = 1'b1;

   typedef enum logic [1:0] {
      OP_OBSERVE,
      OP_CLASSIFY_MISSING,
      OP_CLASSIFY
   } op_type;

   typedef struct packed {
      logic                          command;
      logic [ATTR_BITS-1:0]          attribute;
      logic signed [VALUE_BITS-1:0]  value;
      logic                          unknown;
   } req_type;

   typedef struct packed {
      logic [BIN_BITS-1:0] bin_index;
      logic                unknown_out;
   } rsp_type;

   typedef struct packed {
      op_type                        op;
      logic [ATTR_BITS-1:0]          attr;
      logic                          attr_valid;
      logic signed [VALUE_BITS-1:0]  value;
   } work_type;

endpackage

@@ sv/equal_width_binning_top.sv @@
// top level of the equal-width binning discretizer
// Equal-width discretizer for signed Q16.16 values, one min/max tracker per
// attribute. An observe beat widens its attribute's range and gives no
// result; a classify beat gives one result beat with the bin index. The
// front end decodes beats into a two-entry work queue; the back end works on
// one beat at a time. An observe takes a pop and a range write; a missing,
// never-observed or single-bin classify takes a pop, a range read and a
// result. A ranged classify takes a pop and range read, a division of the
// range by num_bins at one quotient bit per cycle, a walk at one boundary
// add and compare per cycle that ends at boundary k (1..num_bins-1), and the
// result. A result beat can be popped in the cycle after the back end hands
// it over. Results wait in a two-entry output queue, so the back end keeps
// working while the consumer stalls, until that queue is full. num_bins is
// written through the csr port at byte address 0 (reset 10; 0 acts as 1,
// above 64 as 64) and should only change while the block is idle.
`include "equal_width_binning_top_assert.svh"

module equal_width_binning_top #(
   parameter int NUM_ATTRS = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input queue side
   input  logic                                  req_push,
   input  ewb_pkg::req_type                      req_data,
   output logic                                  req_full,
   // result queue side
   output logic                                  rsp_empty,
   output ewb_pkg::rsp_type                      rsp_data,
   input  logic                                  rsp_pop,
   // configuration
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [ewb_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [ewb_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [ewb_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                  csr_pready
);
   localparam int WW = $bits(ewb_pkg::work_type);
   localparam int RW = $bits(ewb_pkg::rsp_type);

   logic [ewb_pkg::NB_BITS-1:0] num_bins_ff, num_bins_in;
   logic                        csr_write;

   logic                        work_push, work_full, work_pop, work_empty;
   ewb_pkg::work_type           work_in, work_out;
   logic [WW-1:0]               work_out_bits;

   logic                        rsp_push, rsp_full;
   ewb_pkg::rsp_type            rsp_in;
   logic [RW-1:0]               rsp_out_bits;

   // csr: single register, always ready
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign num_bins_in = (csr_write && csr_paddr[2] == ewb_pkg::REG_NUM_BINS)
                        ? csr_pwdata[ewb_pkg::NB_BITS-1:0] : num_bins_ff;
   assign csr_prdata = (csr_paddr[2] == ewb_pkg::REG_NUM_BINS)
                       ? ewb_pkg::CSR_DATA_BITS'(num_bins_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_bins_ff <= ewb_pkg::NUM_BINS_RESET;
      end else begin
         num_bins_ff <= num_bins_in;
      end
   end

   // front end: decode and filter
   ewb_front #(.NUM_ATTRS(NUM_ATTRS)) u_front (
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .work_push (work_push),
      .work_data (work_in),
      .work_full (work_full)
   );

   // work queue between front and back
   ewb_fifo #(.WIDTH(WW), .DEPTH(2)) u_work_q (
      .clock (clock),
      .reset (reset),
      .push  (work_push),
      .din   (work_in),
      .full  (work_full),
      .pop   (work_pop),
      .dout  (work_out_bits),
      .empty (work_empty)
   );
   assign work_out = ewb_pkg::work_type'(work_out_bits);

   // back end: range ram, divider, boundary walk
   ewb_back #(.NUM_ATTRS(NUM_ATTRS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .num_bins   (num_bins_ff),
      .work_data  (work_out),
      .work_empty (work_empty),
      .work_pop   (work_pop),
      .rsp_push   (rsp_push),
      .rsp_data   (rsp_in),
      .rsp_full   (rsp_full)
   );

   // result queue
   ewb_fifo #(.WIDTH(RW), .DEPTH(2)) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .din   (rsp_in),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .dout  (rsp_out_bits),
      .empty (rsp_empty)
   );
   assign rsp_data = ewb_pkg::rsp_type'(rsp_out_bits);

   // checks
   `EWB_ASSERT_NEVER(a_rsp_overflow, rsp_push && rsp_full, "result pushed into full queue")
   `EWB_ASSERT_NEVER(a_work_underflow, work_pop && work_empty, "work popped from empty queue")
   `EWB_ASSERT(a_missing_bin_zero, (!rsp_empty && rsp_data.unknown_out) |-> (rsp_data.bin_index == '0), "missing value with nonzero bin")
   `EWB_ASSERT(a_push_drains_front, (work_push && !work_pop) |=> !work_empty, "work beat lost")

endmodule

@@ sv/ewb_ram.sv @@
// generic single-port-write ram with registered read
module ewb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ sv/ewb_fifo.sv @@
// small synchronous fifo
module ewb_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);
   localparam int PW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == (PW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end
endmodule

@@ sv/ewb_front.sv @@
// front end: decodes items, drops observes with an unknown value or an invalid attribute
module ewb_front #(
   parameter int NUM_ATTRS = 64
) (
   input  logic              req_push,
   input  ewb_pkg::req_type  req_data,
   output logic              req_full,
   output logic              work_push,
   output ewb_pkg::work_type work_data,
   input  logic              work_full
);
   logic attr_valid;
   logic drop;

   assign attr_valid = (11'(req_data.attribute) < 11'(NUM_ATTRS));

   always_comb begin
      drop               = 1'b0;
      work_data.attr       = req_data.attribute;
      work_data.attr_valid = attr_valid;
      work_data.value      = req_data.value;
      unique case (req_data.command)
         ewb_pkg::CMD_OBSERVE: begin
            work_data.op = ewb_pkg::OP_OBSERVE;
            drop         = req_data.unknown || !attr_valid;
         end
         ewb_pkg::CMD_CLASSIFY: begin
            work_data.op = req_data.unknown ? ewb_pkg::OP_CLASSIFY_MISSING
                                            : ewb_pkg::OP_CLASSIFY;
         end
         default: begin
            work_data.op = ewb_pkg::OP_OBSERVE;
            drop         = 1'b1;
         end
      endcase
   end

   assign req_full  = work_full;
   assign work_push = req_push && !work_full && !drop;
endmodule

@@ sv/ewb_back.sv @@
// back end: range tracking, width division and boundary walk
module ewb_back #(
   parameter int NUM_ATTRS = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [ewb_pkg::NB_BITS-1:0]  num_bins,
   input  ewb_pkg::work_type            work_data,
   input  logic                         work_empty,
   output logic                         work_pop,
   output logic                         rsp_push,
   output ewb_pkg::rsp_type             rsp_data,
   input  logic                         rsp_full
);
   localparam int AW = (NUM_ATTRS > 1) ? $clog2(NUM_ATTRS) : 1;
   localparam int VB = ewb_pkg::VALUE_BITS;
   localparam int NB = ewb_pkg::NB_BITS;
   localparam int BB = ewb_pkg::BIN_BITS;
   localparam int DW = VB + 1;
   localparam int CW = $clog2(DW);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DATA,
      S_DIV,
      S_WALK,
      S_OUT
   } state_type;

   state_type               state_ff, state_in;
   ewb_pkg::work_type       item_ff, item_in;
   logic [NUM_ATTRS-1:0]    seen_ff, seen_in;
   logic [NB-1:0]           nb_ff, nb_in;
   logic [NB-1:0]           rem_ff, rem_in;
   logic [DW-1:0]           quo_ff, quo_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic signed [VB+1:0]    bound_ff, bound_in;
   logic [NB-1:0]           k_ff, k_in;
   logic [BB-1:0]           bin_ff, bin_in;
   logic                    unk_ff, unk_in;

   logic                    wr_en;
   logic [AW-1:0]           addr_item;
   logic [2*VB-1:0]         wr_data, rd_data;
   logic signed [VB-1:0]    lo, hi, v;
   logic                    seen_bit;
   logic [NB-1:0]           nb_eff;
   logic [NB:0]             div_t;
   logic                    div_ge;
   logic signed [VB+1:0]    bound_next;

   ewb_ram #(.WIDTH(2*VB), .DEPTH(NUM_ATTRS)) u_range_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_item),
      .wr_data (wr_data),
      .rd_en   (work_pop),
      .rd_addr (AW'(work_data.attr)),
      .rd_data (rd_data)
   );

   assign addr_item = AW'(item_ff.attr);
   assign lo        = rd_data[VB-1:0];
   assign hi        = rd_data[2*VB-1:VB];
   assign v         = item_ff.value;
   assign seen_bit  = item_ff.attr_valid && seen_ff[addr_item];
   assign work_pop  = (state_ff == S_IDLE) && !work_empty;
   assign rsp_push  = (state_ff == S_OUT) && !rsp_full;
   assign rsp_data.bin_index   = bin_ff;
   assign rsp_data.unknown_out = unk_ff;

   always_comb begin
      if (num_bins == '0) begin
         nb_eff = NB'(1);
      end else if (num_bins > ewb_pkg::MAX_BINS) begin
         nb_eff = ewb_pkg::MAX_BINS;
      end else begin
         nb_eff = num_bins;
      end
   end

   // one restoring-division step per cycle
   assign div_t      = {rem_ff, quo_ff[DW-1]};
   assign div_ge     = (div_t >= {1'b0, nb_ff});
   assign bound_next = bound_ff + $signed({1'b0, quo_ff});

   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      seen_in  = seen_ff;
      nb_in    = nb_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      bound_in = bound_ff;
      k_in     = k_ff;
      bin_in   = bin_ff;
      unk_in   = unk_ff;
      wr_en    = 1'b0;
      wr_data  = {v, v};
      unique case (state_ff)
         S_IDLE: begin
            if (!work_empty) begin
               item_in  = work_data;
               nb_in    = nb_eff;
               state_in = S_DATA;
            end
         end
         S_DATA: begin
            unk_in = 1'b0;
            bin_in = '0;
            case (item_ff.op)
               ewb_pkg::OP_OBSERVE: begin
                  wr_en = 1'b1;
                  if (seen_bit) begin
                     wr_data = {(v > hi) ? v : hi, (v < lo) ? v : lo};
                  end
                  seen_in[addr_item] = 1'b1;
                  state_in = S_IDLE;
               end
               ewb_pkg::OP_CLASSIFY_MISSING: begin
                  unk_in   = 1'b1;
                  state_in = S_OUT;
               end
               ewb_pkg::OP_CLASSIFY: begin
                  if (!seen_bit) begin
                     bin_in   = (v < ewb_pkg::ONE_Q16) ? BB'(0) : BB'(1);
                     state_in = S_OUT;
                  end else if (nb_ff == NB'(1)) begin
                     state_in = S_OUT;
                  end else begin
                     quo_in   = DW'($signed({hi[VB-1], hi}) - $signed({lo[VB-1], lo}));
                     rem_in   = '0;
                     cnt_in   = '0;
                     bound_in = (VB+2)'(lo);
                     state_in = S_DIV;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_DIV: begin
            rem_in = div_ge ? NB'(div_t - {1'b0, nb_ff}) : div_t[NB-1:0];
            quo_in = {quo_ff[DW-2:0], div_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(DW - 1)) begin
               k_in     = NB'(1);
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            bound_in = bound_next;
            if ($signed({v[VB-1], v[VB-1], v}) < bound_next) begin
               bin_in   = BB'(k_ff - 1'b1);
               state_in = S_OUT;
            end else if (k_ff == nb_ff - 1'b1) begin
               bin_in   = BB'(nb_ff - 1'b1);
               state_in = S_OUT;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_OUT: begin
            if (!rsp_full) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         seen_ff  <= '0;
      end else begin
         state_ff <= state_in;
         seen_ff  <= seen_in;
      end
      item_ff  <= item_in;
      nb_ff    <= nb_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      bound_ff <= bound_in;
      k_ff     <= k_in;
      bin_ff   <= bin_in;
      unk_ff   <= unk_in;
   end
endmodule
